>>> src/me_pkg.sv
// ----------------------------------------------------------------------------
// me_pkg
// Shared types and constants for the modular exponentiation block: item
// payloads, controller-to-datapath commands and datapath status.
// ----------------------------------------------------------------------------
package me_pkg;

  // Fixed field width of every payload word
  localparam int FIELD_W       = 64;
  // Default operand width inside the datapath
  localparam int WORD_BITS_DEF = 64;

  typedef struct packed {
    logic [FIELD_W-1:0] base_value;
    logic [FIELD_W-1:0] power;
    logic [FIELD_W-1:0] modulus_value;
  } me_in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] result_value;
    logic               zero_modulus;
  } me_out_item_t;

  // Operand source for a pass of the shared modular multiplier
  typedef enum logic [1:0] {
    SRC_REDUCE = 2'd0,  // base * 1: reduce the raw base
    SRC_SQUARE = 2'd1,  // acc * acc
    SRC_MULT   = 2'd2   // acc * reduced base
  } me_src_t;

  typedef struct packed {
    logic    load;       // capture a new input item
    logic    mul_start;  // clear partial result, load operands
    me_src_t mul_src;
    logic    mul_step;   // one multiplier bit step
    logic    save_base;  // step result goes to the base register
    logic    save_acc;   // step result goes to the accumulator
    logic    take_base;  // accumulator takes the reduced base
    logic    shift_exp;  // consume one exponent bit
    logic    out_load;   // fill the output register
  } me_cmd_t;

  typedef struct packed {
    logic mod_zero;
    logic exp_msb;
  } me_sts_t;

endpackage

>>> src/me_stream_if.sv
// ----------------------------------------------------------------------------
// me_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface me_stream_if #(
  parameter type PAYLOAD_T = logic
);
  logic     valid;
  logic     ready;
  PAYLOAD_T payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> src/me_datapath.sv
// ----------------------------------------------------------------------------
// me_datapath
// Operand registers, the exponent shifter and a bit-serial modular
// multiplier (one multiplier bit per cycle), plus the output register.
// ----------------------------------------------------------------------------
module me_datapath #(
  parameter int WORD_BITS = me_pkg::WORD_BITS_DEF
) (
  input  logic                clk,
  input  me_pkg::me_in_item_t in_item,
  input  me_pkg::me_cmd_t     cmd,
  output me_pkg::me_sts_t     sts,
  output me_pkg::me_out_item_t out_item
);
  import me_pkg::*;

  localparam int T_W = WORD_BITS + 2;

  logic [WORD_BITS-1:0] mod_r, base_r, acc_r, exp_r, a_r, bsh_r, r_r;
  logic                 zero_r;
  logic [FIELD_W-1:0]   res_r;
  logic                 zm_r;

  logic [WORD_BITS-1:0] addend;
  logic [T_W-1:0]       t_sum, m1, m2;
  logic [WORD_BITS-1:0] r_step;

  // One step: r = (2r + bit * a) mod m, with 2r + bit * a below 3m
  always_comb begin
    addend = bsh_r[WORD_BITS-1] ? a_r : '0;
    t_sum  = {1'b0, r_r, 1'b0} + {2'b00, addend};
    m1     = {2'b00, mod_r};
    m2     = {1'b0, mod_r, 1'b0};
    if (t_sum >= m2) begin
      r_step = WORD_BITS'(t_sum - m2);
    end else if (t_sum >= m1) begin
      r_step = WORD_BITS'(t_sum - m1);
    end else begin
      r_step = WORD_BITS'(t_sum);
    end
  end

  // Operand and multiplier registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r <= in_item.base_value[WORD_BITS-1:0];
      exp_r  <= in_item.power[WORD_BITS-1:0];
      mod_r  <= in_item.modulus_value[WORD_BITS-1:0];
      zero_r <= (in_item.modulus_value[WORD_BITS-1:0] == '0);
      acc_r  <= WORD_BITS'(1);
    end
    if (cmd.mul_start) begin
      r_r <= '0;
      case (cmd.mul_src)
        SRC_REDUCE: begin
          a_r   <= WORD_BITS'(1);
          bsh_r <= base_r;
        end
        SRC_SQUARE: begin
          a_r   <= acc_r;
          bsh_r <= acc_r;
        end
        default: begin
          a_r   <= acc_r;
          bsh_r <= base_r;
        end
      endcase
    end
    if (cmd.mul_step) begin
      r_r   <= r_step;
      bsh_r <= bsh_r << 1;
    end
    if (cmd.save_base) begin
      base_r <= r_step;
    end
    if (cmd.save_acc) begin
      acc_r <= r_step;
    end
    if (cmd.take_base) begin
      acc_r <= base_r;
    end
    if (cmd.shift_exp) begin
      exp_r <= exp_r << 1;
    end
    if (cmd.out_load) begin
      res_r <= zero_r ? '0 : FIELD_W'(acc_r);
      zm_r  <= zero_r;
    end
  end

  assign sts.mod_zero = zero_r;
  assign sts.exp_msb  = exp_r[WORD_BITS-1];

  assign out_item.result_value = res_r;
  assign out_item.zero_modulus = zm_r;

endmodule

>>> src/me_ctrl.sv
// ----------------------------------------------------------------------------
// me_ctrl
// Sequencer for left-to-right square-and-multiply: reduces the base, then
// walks the exponent bits, issuing square and multiply passes to the datapath.
// ----------------------------------------------------------------------------
module me_ctrl #(
  parameter int WORD_BITS = me_pkg::WORD_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  me_pkg::me_sts_t sts,
  output me_pkg::me_cmd_t cmd
);
  import me_pkg::*;

  localparam int CNT_W = $clog2(WORD_BITS + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(WORD_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_REDUCE, S_SCAN, S_SQUARE, S_CHECK, S_MULT, S_NEXT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] bit_r, bit_nxt;
  logic             started_r, started_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             fin_r, fin_nxt;

  // Next-state and command decode
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    bit_nxt       = bit_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r;
    fin_nxt       = fin_r;
    cmd           = '0;
    cmd.mul_src   = SRC_REDUCE;
    in_ready      = 1'b0;

    // Drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        in_ready = !fin_r;
        if (fin_r) begin
          // Hold the finished item until the output register frees up
          if (!out_valid_r || out_ready) begin
            cmd.out_load  = 1'b1;
            out_valid_nxt = 1'b1;
            fin_nxt       = 1'b0;
          end
        end else if (in_valid) begin
          cmd.load    = 1'b1;
          bit_nxt     = '0;
          started_nxt = 1'b0;
          state_nxt   = S_START;
        end
      end
      S_START: begin
        if (sts.mod_zero) begin
          fin_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_src   = SRC_REDUCE;
          cnt_nxt       = '0;
          state_nxt     = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          cmd.save_base = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (started_r) begin
          cmd.mul_start = 1'b1;
          cmd.mul_src   = SRC_SQUARE;
          cnt_nxt       = '0;
          state_nxt     = S_SQUARE;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_SQUARE: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          cmd.save_acc = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.exp_msb && started_r) begin
          cmd.mul_start = 1'b1;
          cmd.mul_src   = SRC_MULT;
          cnt_nxt       = '0;
          state_nxt     = S_MULT;
        end else if (sts.exp_msb) begin
          // First set bit: 1 * base is the reduced base itself
          cmd.take_base = 1'b1;
          started_nxt   = 1'b1;
          state_nxt     = S_NEXT;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_MULT: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          cmd.save_acc = 1'b1;
          state_nxt    = S_NEXT;
        end
      end
      S_NEXT: begin
        cmd.shift_exp = 1'b1;
        bit_nxt       = bit_r + 1'b1;
        if (bit_r == LAST) begin
          fin_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      bit_r       <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
      fin_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      bit_r       <= bit_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
      fin_r       <= fin_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> src/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base ^ power mod modulus by left-to-right square-and-multiply on
// a shared bit-serial modular multiplier.
//
//   channel | dir | handshake     | payload
//   in_if   | in  | valid & ready | base_value, power, modulus_value
//   out_if  | out | valid & ready | result_value, zero_modulus
//
// An item's run time is set by the multiplier, which retires one operand bit per
// cycle: one pass reduces the base, then square and multiply passes follow as
// the exponent bits call for. A zero modulus skips all passes.
// One item is in work at a time; in_if.ready rises again once the result is
// in the output register, even while out_if is stalled.
// Reset (rst_n low, synchronous) empties the output register and idles.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int WORD_BITS = me_pkg::WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  me_stream_if.sink   in_if,
  me_stream_if.source out_if
);
  import me_pkg::*;

  me_cmd_t      cmd;
  me_sts_t      sts;
  me_in_item_t  in_item;
  me_out_item_t out_item;

  assign in_item        = in_if.payload;
  assign out_if.payload = out_item;

  // Sequencer
  me_ctrl #(
    .WORD_BITS(WORD_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .out_valid(out_if.valid),
    .out_ready(out_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Operands and multiplier
  me_datapath #(
    .WORD_BITS(WORD_BITS)
  ) u_datapath (
    .clk     (clk),
    .in_item (in_item),
    .cmd     (cmd),
    .sts     (sts),
    .out_item(out_item)
  );

endmodule

>>> src/me_checker.sv
// ----------------------------------------------------------------------------
// me_checker
// Port-level checks for the modular exponentiation block, bound to its top.
// ----------------------------------------------------------------------------
module me_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_result,
  input logic        out_zero
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_zero))
    else $error("stalled result changed");

  // A zero modulus always reports a zero result
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero |-> out_result == 64'd0)
    else $error("zero modulus with nonzero result");

  // Close the input once an item is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still open after accept");

  // Reset empties the output register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind modular_exponentiation me_checker u_me_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_result(out_if.payload.result_value),
  .out_zero  (out_if.payload.zero_modulus)
);

>>> tb/modular_exponentiation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_tb
// Self-checking bench for the modular exponentiation block. A directed set
// covers zero and unit moduli, zero powers and all-ones operands. A random
// set follows, with mostly short exponents and some full-width ones. Each
// item accepted on the input is predicted with full 128-bit products, and
// each result taken from the output is checked against the oldest
// prediction. Both sides idle in short random bursts, and once the receiver
// holds off long enough to back the block up onto its input.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb;
  import me_pkg::*;

  localparam int OP_BITS         = WORD_BITS_DEF;
  localparam int HOLD_AT         = 4;       // results seen before the long hold-off
  localparam int HOLD_CYCLES     = 20000;   // longer than two full-width items
  localparam int CALM_ITEMS      = 15;      // closing stretch with no idling
  localparam int RANDOM_ITEMS    = 100;
  localparam int DRAIN_CYCLES    = 50;
  localparam int WATCHDOG_CYCLES = 100000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic         in_valid_q  = 1'b0;
  me_in_item_t  in_item_q   = '0;
  logic         out_ready_q = 1'b0;

  me_stream_if #(.PAYLOAD_T(me_in_item_t))  in_if ();
  me_stream_if #(.PAYLOAD_T(me_out_item_t)) out_if ();

  assign in_if.valid   = in_valid_q;
  assign in_if.payload = in_item_q;
  assign out_if.ready  = out_ready_q;

  modular_exponentiation #(
    .WORD_BITS(OP_BITS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  me_in_item_t  operand_queue[$];
  me_out_item_t residue_queue[$];

  int total_items  = 0;
  int items_taken  = 0;
  int results_seen = 0;
  int err_count    = 0;
  int in_gap       = 0;
  int out_gap      = 0;
  int hold_left    = 0;
  int idle_cycles  = 0;
  bit hold_done    = 1'b0;
  bit take_in;

  always #5 clk = ~clk;

  // Expected residue of base^power mod modulus, products kept at full width
  function automatic me_out_item_t power_mod(me_in_item_t item);
    logic [63:0]  mask;
    logic [63:0]  b;
    logic [63:0]  e;
    logic [63:0]  m;
    logic [63:0]  acc;
    logic [127:0] prod;
    bit           started;
    int           n;
    me_out_item_t res;
    mask = {64{1'b1}} >> (64 - OP_BITS);
    b = item.base_value & mask;
    e = item.power & mask;
    m = item.modulus_value & mask;
    res.result_value = '0;
    res.zero_modulus = 1'b1;
    if (m == 0) begin
      return res;
    end
    acc     = 64'd1;
    started = 1'b0;
    for (n = 0; n < OP_BITS; n++) begin
      if (started) begin
        prod = {64'd0, acc} * {64'd0, acc};
        prod = prod % {64'd0, m};
        acc  = prod[63:0];
      end
      if (e[OP_BITS-1-n]) begin
        prod    = {64'd0, acc} * {64'd0, b};
        prod    = prod % {64'd0, m};
        acc     = prod[63:0];
        started = 1'b1;
      end
    end
    res.result_value = acc;
    res.zero_modulus = 1'b0;
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random value confined to its low w bits, w in 1..64
  function automatic logic [63:0] rand_bits(int w);
    return rand64() >> (64 - w);
  endfunction

  task automatic add_item(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    me_in_item_t item;
    item.base_value    = b;
    item.power         = e;
    item.modulus_value = m;
    operand_queue.push_back(item);
  endtask

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Driver: hold each item until accepted, predict it on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid_q <= 1'b0;
      in_gap = 0;
    end else begin
      take_in = in_valid_q && in_if.ready;
      if (take_in) begin
        residue_queue.push_back(power_mod(in_item_q));
        items_taken++;
        if (items_taken < total_items - CALM_ITEMS && $urandom_range(0, 3) == 0) begin
          in_gap = $urandom_range(1, 5);
        end
      end
      if (!in_valid_q || take_in) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_q <= 1'b0;
        end else if (operand_queue.size() > 0) begin
          in_item_q  <= operand_queue.pop_front();
          in_valid_q <= 1'b1;
        end else begin
          in_valid_q <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result, stall the output in bursts and once for long
  always @(posedge clk) begin
    me_out_item_t want;
    if (!rst_n) begin
      out_ready_q <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_ready_q && out_if.valid) begin
        results_seen++;
        if (residue_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h zero_modulus %b",
                                    out_if.payload.result_value,
                                    out_if.payload.zero_modulus));
        end else begin
          want = residue_queue.pop_front();
          if (out_if.payload.result_value !== want.result_value) begin
            report_mismatch($sformatf("result %0d: result_value %h, want %h", results_seen,
                                      out_if.payload.result_value, want.result_value));
          end
          if (out_if.payload.zero_modulus !== want.zero_modulus) begin
            report_mismatch($sformatf("result %0d: zero_modulus %b, want %b", results_seen,
                                      out_if.payload.zero_modulus, want.zero_modulus));
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && results_seen == HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left == 0 && out_gap == 0 && results_seen < total_items - CALM_ITEMS &&
          $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(1, 5);
      end
      if (hold_left > 0) begin
        out_ready_q <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready_q <= 1'b0;
      end else begin
        out_ready_q <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid_q && in_if.ready) || (out_ready_q && out_if.valid)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("TIMEOUT after %0d idle cycles", idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int          i;
    int          pick;
    logic [63:0] b;
    logic [63:0] e;
    logic [63:0] m;

    // Zero modulus, with zero and nonzero powers
    add_item(rand64(), 64'd0, 64'd0);
    add_item({64{1'b1}}, {64{1'b1}}, 64'd0);
    // Zero power returns an unreduced one
    add_item(rand64(), 64'd0, 64'd1);
    add_item({64{1'b1}}, 64'd0, {64{1'b1}});
    // Small known cases
    add_item(64'd2, 64'd10, 64'd1000);
    add_item(64'd0, 64'd5, 64'd7);
    add_item(64'd3, 64'd1, 64'd3);
    add_item(rand64(), 64'd1, 64'd1);
    add_item(rand64(), rand64(), 64'd1);
    add_item(64'd1, {64{1'b1}}, rand64());
    // All-ones operands and a large prime modulus
    add_item({64{1'b1}}, {64{1'b1}}, {64{1'b1}});
    add_item({64{1'b1}}, {64{1'b1}}, 64'hFFFF_FFFF_FFFF_FFC5);
    add_item({64{1'b1}}, 64'd1, {64{1'b1}} - 64'd1);
    // Single exponent bit at the top, and an alternating exponent
    add_item(rand64(), 64'h8000_0000_0000_0000, rand64());
    add_item(rand64(), 64'hAAAA_AAAA_AAAA_AAAA, rand64());
    add_item(rand64(), 64'h5555_5555_5555_5555, 64'h8000_0000_0000_0001);
    // Base equal to and above the modulus
    m = rand64();
    add_item(m, rand_bits(16), m);
    add_item({64{1'b1}}, rand_bits(20), rand_bits(12));

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        e = 64'd0;
      end else if (pick <= 3) begin
        e = rand64();
      end else begin
        e = rand_bits($urandom_range(1, 32));
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        m = 64'd0;
      end else if (pick == 1) begin
        m = 64'd1;
      end else if (pick <= 4) begin
        m = rand_bits($urandom_range(1, 64));
      end else begin
        m = rand64();
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        b = 64'd0;
      end else if (pick == 1) begin
        b = {64{1'b1}};
      end else if (pick <= 4) begin
        b = rand_bits($urandom_range(1, 64));
      end else begin
        b = rand64();
      end
      add_item(b, e, m);
    end
    total_items = operand_queue.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (items_taken < total_items || residue_queue.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
